// File: hdl/m4i_pkg.sv
// m4i_pkg: shared types, widths and helper functions of the 4x4 matrix inverse unit
// no dependencies; used by m4i_mul, m4i_div and matrix4x4_inverse_unit
`default_nettype none
package m4i_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int ELEM_WIDTH = 32;
  localparam int CELLS      = 16;
  localparam int IDX_W      = 4;
  localparam int COF_W      = 64;
  localparam int LIMB_W     = 32;
  // magnitude of one 64 x ELEM_WIDTH product
  localparam int PROD_W     = COF_W + ELEM_WIDTH;
  // signed sum of six shifted triple products
  localparam int ACC_W      = PROD_W + 1 - FRAC_BITS + 3;
  // signed sum of four determinant products
  localparam int DET_W      = PROD_W + 3;
  // adjugate magnitude shifted up by twice the fraction
  localparam int NUM_W      = COF_W + 2 * FRAC_BITS;
  localparam int WIDE_W     = 128;
  localparam int TERMS      = 6;

  typedef struct packed {
    logic [IDX_W-1:0]             element_index;
    logic signed [ELEM_WIDTH-1:0] element_value;
    logic                         last_element;
  } elem_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]             result_index;
    logic signed [ELEM_WIDTH-1:0] result_value;
    logic                         singular;
    logic                         saturated;
    logic                         last_result;
  } res_item_t;

  typedef struct packed {
    logic                    clip;
    logic signed [COF_W-1:0] val;
  } sat64_t;

  // clip a wide signed value into 64 bits
  function automatic sat64_t sat64(input logic signed [WIDE_W-1:0] x);
    sat64_t r;
    if (x[WIDE_W-1:COF_W-1] == {(WIDE_W-COF_W+1){1'b0}} ||
        x[WIDE_W-1:COF_W-1] == {(WIDE_W-COF_W+1){1'b1}}) begin
      r.clip = 1'b0;
      r.val  = x[COF_W-1:0];
    end else begin
      r.clip = 1'b1;
      r.val  = x[WIDE_W-1] ? {1'b1, {(COF_W-1){1'b0}}} : {1'b0, {(COF_W-1){1'b1}}};
    end
    return r;
  endfunction

  // matrix index of factor pos of triple term for the cofactor at (row, col)
  function automatic logic [IDX_W-1:0] elem_index(input logic [1:0] row, input logic [1:0] col,
                                                  input logic [2:0] term, input logic [1:0] pos);
    logic [1:0] mc;
    logic [1:0] r;
    logic [1:0] c;
    case (term)
      3'd0:    mc = pos;
      3'd1:    mc = (pos == 2'd2) ? 2'd0 : pos + 2'd1;
      3'd2:    mc = (pos == 2'd0) ? 2'd2 : pos - 2'd1;
      3'd3:    mc = 2'd2 - pos;
      3'd4:    mc = (pos == 2'd0) ? 2'd0 : 2'd3 - pos;
      3'd5:    mc = (pos == 2'd2) ? 2'd2 : 2'd1 - pos;
      default: mc = pos;
    endcase
    r = (pos >= row) ? pos + 2'd1 : pos;
    c = (mc >= col) ? mc + 2'd1 : mc;
    return {r, c};
  endfunction

endpackage
`default_nettype wire

// File: hdl/m4i_mul.sv
// m4i_mul: shared multiplier, 64-bit by ELEM_WIDTH-bit unsigned magnitudes
// one 32-bit limb per pass through a single multiplier; uses m4i_pkg
`default_nettype none
module m4i_mul (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [m4i_pkg::COF_W-1:0]     a,
  input  wire logic [m4i_pkg::ELEM_WIDTH-1:0] b,
  output logic                               done,
  output logic [m4i_pkg::PROD_W-1:0]         prod
);

  logic [1:0] phase;
  logic [m4i_pkg::LIMB_W+m4i_pkg::ELEM_WIDTH-1:0] pp;
  logic [m4i_pkg::PROD_W-1:0] acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 2'd0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (phase)
        2'd0: begin
          if (start) phase <= 2'd1;
        end
        2'd1: begin
          pp    <= a[m4i_pkg::LIMB_W-1:0] * b;
          phase <= 2'd2;
        end
        2'd2: begin
          acc   <= m4i_pkg::PROD_W'(pp);
          pp    <= a[m4i_pkg::COF_W-1:m4i_pkg::LIMB_W] * b;
          phase <= 2'd3;
        end
        default: begin
          prod  <= acc + (m4i_pkg::PROD_W'(pp) << m4i_pkg::LIMB_W);
          done  <= 1'b1;
          phase <= 2'd0;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hdl/m4i_div.sv
// m4i_div: restoring divider, one quotient bit per cycle
// unsigned NUM_W-bit numerator over DET_W-bit divisor; uses m4i_pkg
`default_nettype none
module m4i_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [m4i_pkg::NUM_W-1:0]  num,
  input  wire logic [m4i_pkg::DET_W-1:0]  den,
  output logic                            done,
  output logic [m4i_pkg::NUM_W-1:0]       quot
);

  localparam int CNT_W = $clog2(m4i_pkg::NUM_W);

  logic                        busy;
  logic [CNT_W-1:0]            count;
  logic [m4i_pkg::DET_W-1:0]   rem;
  logic [m4i_pkg::NUM_W-1:0]   nsh;
  logic [m4i_pkg::DET_W:0]     cand;
  logic                        ge;

  assign cand = {rem, nsh[m4i_pkg::NUM_W-1]};
  assign ge   = cand >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (!busy) begin
        if (start) begin
          busy  <= 1'b1;
          count <= '0;
          rem   <= '0;
          nsh   <= num;
          quot  <= '0;
        end
      end else begin
        rem   <= ge ? m4i_pkg::DET_W'(cand - {1'b0, den}) : cand[m4i_pkg::DET_W-1:0];
        nsh   <= {nsh[m4i_pkg::NUM_W-2:0], 1'b0};
        quot  <= {quot[m4i_pkg::NUM_W-2:0], ge};
        count <= count + 1'b1;
        if (count == CNT_W'(m4i_pkg::NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: hdl/matrix4x4_inverse_unit.sv
// 4x4 matrix inverse unit: 16 elements are loaded one item each over the elem
// channel (valid/ready); the item flagged last_element starts the inversion.
// Elements are signed Q16.16 at their row-major index.
// The 16 cofactors are built from six triple products each on one shared
// multiplier (two 32-bit limb passes per product), followed by the determinant
// and one restoring division per result, one quotient bit per cycle.
// Each result waits for its own division on the 96-step divider.
// A singular matrix skips the divider for all 16 of its results.
// elem_ready is high only while the unit is idle; a run cannot overlap the next
// load. Results leave through an output register on the res channel; when the
// receiver stalls the sequencer waits with the next result and loses nothing.
// Reset (rst, synchronous) returns the sequencer to idle and drops res_valid;
// matrix and cofactor memories hold no reset value.
// Depends on m4i_pkg, m4i_mul and m4i_div.
`default_nettype none
module matrix4x4_inverse_unit (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                elem_valid,
  output logic                     elem_ready,
  input  wire m4i_pkg::elem_item_t elem,
  output logic                     res_valid,
  input  wire logic                res_ready,
  output m4i_pkg::res_item_t       res
);

  localparam int E  = m4i_pkg::ELEM_WIDTH;
  localparam int CW = m4i_pkg::COF_W;
  localparam int PW = m4i_pkg::PROD_W;
  localparam int F  = m4i_pkg::FRAC_BITS;

  typedef enum logic [15:0] {
    S_IDLE     = 16'h0001,
    S_RD_A     = 16'h0002,
    S_RD_B     = 16'h0004,
    S_RD_C     = 16'h0008,
    S_MUL_AB   = 16'h0010,
    S_WAIT_AB  = 16'h0020,
    S_MUL_C    = 16'h0040,
    S_WAIT_C   = 16'h0080,
    S_COF_WR   = 16'h0100,
    S_DET_RD   = 16'h0200,
    S_DET_MUL  = 16'h0400,
    S_DET_WAIT = 16'h0800,
    S_DIV_RD   = 16'h1000,
    S_DIV_GO   = 16'h2000,
    S_DIV_WAIT = 16'h4000,
    S_EMIT     = 16'h8000
  } state_t;

  state_t state;

  logic signed [E-1:0]  mat [m4i_pkg::CELLS];
  logic signed [CW-1:0] cof_mem [m4i_pkg::CELLS];
  logic signed [E-1:0]  mat_q;
  logic signed [CW-1:0] cof_q;
  logic [m4i_pkg::IDX_W-1:0] mat_addr;
  logic [m4i_pkg::IDX_W-1:0] cof_addr;

  logic [m4i_pkg::IDX_W-1:0] cnt;
  logic [2:0]                term;
  logic [m4i_pkg::CELLS-1:0] cclip;
  logic                      clip_run;
  logic signed [E-1:0]       op_a;
  logic signed [E-1:0]       op_b;
  logic signed [E-1:0]       op_c;
  logic signed [CW-1:0]      ab;
  logic signed [m4i_pkg::ACC_W-1:0] acc;
  logic signed [m4i_pkg::DET_W-1:0] det;
  logic                      res_neg;

  logic                      mul_start;
  logic [CW-1:0]             mul_a;
  logic [E-1:0]              mul_b;
  logic                      mul_neg;
  logic                      mul_done;
  logic [PW-1:0]             mul_prod;

  logic                          div_start;
  logic [m4i_pkg::NUM_W-1:0]     div_num;
  logic [m4i_pkg::DET_W-1:0]     det_mag;
  logic                          div_done;
  logic [m4i_pkg::NUM_W-1:0]     div_quot;

  logic signed [PW:0]   mul_sprod;
  logic signed [PW-F:0] mul_shift;
  m4i_pkg::sat64_t      ab_sat;
  m4i_pkg::sat64_t      cof_sat;
  logic signed [m4i_pkg::ACC_W-1:0] term_ext;
  logic signed [m4i_pkg::ACC_W-1:0] acc_fin;
  logic [1:0]           row;
  logic [1:0]           col;
  logic                 detclip;
  logic                 det_zero;
  logic                 emit_fire;
  logic [m4i_pkg::NUM_W-1:0] lim;
  logic                 over;
  logic [E-1:0]         qv;

  m4i_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  m4i_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (det_mag),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign row        = cnt[3:2];
  assign col        = cnt[1:0];
  assign elem_ready = (state == S_IDLE);
  assign mul_sprod  = mul_neg ? -$signed({1'b0, mul_prod}) : $signed({1'b0, mul_prod});
  // floor shift of the signed product
  assign mul_shift  = $signed(mul_sprod[PW:F]);
  assign ab_sat     = m4i_pkg::sat64(m4i_pkg::WIDE_W'(mul_shift));
  assign term_ext   = m4i_pkg::ACC_W'(mul_shift);
  assign acc_fin    = (row[0] ^ col[0]) ? -acc : acc;
  assign cof_sat    = m4i_pkg::sat64(m4i_pkg::WIDE_W'(acc_fin));
  assign detclip    = cclip[0] | cclip[4] | cclip[8] | cclip[12];
  assign det_zero   = (det == '0);
  assign det_mag    = det[m4i_pkg::DET_W-1] ? $unsigned(-det) : $unsigned(det);
  assign emit_fire  = (state == S_EMIT) && (!res_valid || res_ready);
  assign lim        = (m4i_pkg::NUM_W'(1) << (E - 1)) - m4i_pkg::NUM_W'(!res_neg);
  assign over       = div_quot > lim;
  assign qv         = over ? lim[E-1:0] : div_quot[E-1:0];

  always_comb begin
    unique case (state)
      S_RD_A:   mat_addr = m4i_pkg::elem_index(row, col, term, 2'd0);
      S_RD_B:   mat_addr = m4i_pkg::elem_index(row, col, term, 2'd1);
      S_RD_C:   mat_addr = m4i_pkg::elem_index(row, col, term, 2'd2);
      S_DET_RD: mat_addr = cnt;
      default:  mat_addr = cnt;
    endcase
    unique case (state)
      S_DET_RD: cof_addr = {cnt[1:0], 2'b00};
      default:  cof_addr = cnt;
    endcase
  end

  always_ff @(posedge clk) begin
    if (elem_valid && elem_ready) mat[elem.element_index] <= elem.element_value;
    mat_q <= mat[mat_addr];
    if (state == S_COF_WR) cof_mem[{col, row}] <= cof_sat.val;
    cof_q <= cof_mem[cof_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      mul_start <= 1'b0;
      div_start <= 1'b0;
      cnt       <= '0;
      term      <= '0;
    end else begin
      mul_start <= 1'b0;
      div_start <= 1'b0;
      if (res_valid && res_ready) res_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (elem_valid && elem.last_element) begin
            cnt      <= '0;
            term     <= '0;
            acc      <= '0;
            clip_run <= 1'b0;
            state    <= S_RD_A;
          end
        end
        S_RD_A: state <= S_RD_B;
        S_RD_B: begin
          op_a  <= mat_q;
          state <= S_RD_C;
        end
        S_RD_C: begin
          op_b  <= mat_q;
          state <= S_MUL_AB;
        end
        S_MUL_AB: begin
          op_c      <= mat_q;
          mul_a     <= CW'(op_a[E-1] ? $unsigned(-op_a) : $unsigned(op_a));
          mul_b     <= op_b[E-1] ? $unsigned(-op_b) : $unsigned(op_b);
          mul_neg   <= op_a[E-1] ^ op_b[E-1];
          mul_start <= 1'b1;
          state     <= S_WAIT_AB;
        end
        S_WAIT_AB: begin
          if (mul_done) begin
            ab       <= ab_sat.val;
            clip_run <= clip_run | ab_sat.clip;
            state    <= S_MUL_C;
          end
        end
        S_MUL_C: begin
          mul_a     <= ab[CW-1] ? $unsigned(-ab) : $unsigned(ab);
          mul_b     <= op_c[E-1] ? $unsigned(-op_c) : $unsigned(op_c);
          mul_neg   <= ab[CW-1] ^ op_c[E-1];
          mul_start <= 1'b1;
          state     <= S_WAIT_C;
        end
        S_WAIT_C: begin
          if (mul_done) begin
            // the last three terms of a minor are subtracted
            acc <= (term >= 3'd3) ? acc - term_ext : acc + term_ext;
            if (term == 3'(m4i_pkg::TERMS - 1)) begin
              state <= S_COF_WR;
            end else begin
              term  <= term + 3'd1;
              state <= S_RD_A;
            end
          end
        end
        S_COF_WR: begin
          cclip[{col, row}] <= clip_run | cof_sat.clip;
          acc      <= '0;
          clip_run <= 1'b0;
          term     <= '0;
          cnt      <= cnt + 1'b1;
          if (cnt == 4'(m4i_pkg::CELLS - 1)) begin
            det   <= '0;
            state <= S_DET_RD;
          end else begin
            state <= S_RD_A;
          end
        end
        S_DET_RD: state <= S_DET_MUL;
        S_DET_MUL: begin
          mul_a     <= cof_q[CW-1] ? $unsigned(-cof_q) : $unsigned(cof_q);
          mul_b     <= mat_q[E-1] ? $unsigned(-mat_q) : $unsigned(mat_q);
          mul_neg   <= cof_q[CW-1] ^ mat_q[E-1];
          mul_start <= 1'b1;
          state     <= S_DET_WAIT;
        end
        S_DET_WAIT: begin
          if (mul_done) begin
            det <= det + m4i_pkg::DET_W'(mul_sprod);
            if (cnt == 4'd3) begin
              cnt   <= '0;
              state <= S_DIV_RD;
            end else begin
              cnt   <= cnt + 1'b1;
              state <= S_DET_RD;
            end
          end
        end
        S_DIV_RD: state <= S_DIV_GO;
        S_DIV_GO: begin
          res_neg <= cof_q[CW-1] ^ det[m4i_pkg::DET_W-1];
          div_num <= {(cof_q[CW-1] ? $unsigned(-cof_q) : $unsigned(cof_q)), {(2*F){1'b0}}};
          if (det_zero) begin
            state <= S_EMIT;
          end else begin
            div_start <= 1'b1;
            state     <= S_DIV_WAIT;
          end
        end
        S_DIV_WAIT: begin
          if (div_done) state <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_fire) begin
            res_valid        <= 1'b1;
            res.result_index <= cnt;
            res.last_result  <= (cnt == 4'(m4i_pkg::CELLS - 1));
            res.singular     <= det_zero;
            if (det_zero) begin
              res.result_value <= '0;
              res.saturated    <= 1'b0;
            end else begin
              res.result_value <= res_neg ? -$signed(qv) : $signed(qv);
              res.saturated    <= over | cclip[cnt] | detclip;
            end
            cnt <= cnt + 1'b1;
            if (cnt == 4'(m4i_pkg::CELLS - 1)) state <= S_IDLE;
            else state <= S_DIV_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_mul_done_waited: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == S_WAIT_AB || state == S_WAIT_C || state == S_DET_WAIT))
    else $error("multiplier finished outside a waiting state");

  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV_WAIT)
    else $error("divider finished outside its waiting state");

  a_run_starts: assert property (@(posedge clk) disable iff (rst)
    elem_valid && elem_ready && elem.last_element |=> state == S_RD_A && cnt == '0)
    else $error("last element did not start a run");

  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.singular |-> res.result_value == '0 && !res.saturated)
    else $error("singular result carries a value");

endmodule
`default_nettype wire

// File: bench/matrix4x4_inverse_unit_tb.sv
// matrix4x4_inverse_unit_tb: loads 4x4 matrices over the element channel and checks all
// 16 inverse results against a fixed-point cofactor/adjugate predictor in a small class.
// Depends on m4i_pkg and matrix4x4_inverse_unit.
`default_nettype none

class inverse_scoreboard;
  logic signed [63:0] mat[16];
  m4i_pkg::res_item_t pending[$];
  int mismatches;
  int checked;

  function logic signed [63:0] clip64(input logic signed [127:0] x, inout bit clip);
    if (x[127:63] == '0 || x[127:63] == '1) return x[63:0];
    clip = 1'b1;
    return x[127] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
  endfunction

  function logic signed [127:0] triple(input logic signed [127:0] a, b, c, inout bit clip);
    logic signed [127:0] ab;
    logic signed [127:0] p;
    p = a * b;
    ab = clip64(p >>> m4i_pkg::FRAC_BITS, clip);
    p = ab * c;
    return p >>> m4i_pkg::FRAC_BITS;
  endfunction

  function logic signed [63:0] cofactor(input int row, input int col, inout bit clip);
    logic signed [127:0] m[3][3];
    logic signed [127:0] acc;
    int ri;
    int ci;
    ri = 0;
    for (int r = 0; r < 4; r++) begin
      if (r != row) begin
        ci = 0;
        for (int c = 0; c < 4; c++) begin
          if (c != col) begin
            m[ri][ci] = mat[r * 4 + c];
            ci++;
          end
        end
        ri++;
      end
    end
    acc = triple(m[0][0], m[1][1], m[2][2], clip);
    acc += triple(m[0][1], m[1][2], m[2][0], clip);
    acc += triple(m[0][2], m[1][0], m[2][1], clip);
    acc -= triple(m[0][2], m[1][1], m[2][0], clip);
    acc -= triple(m[0][0], m[1][2], m[2][1], clip);
    acc -= triple(m[0][1], m[1][0], m[2][2], clip);
    if ((row + col) % 2 == 1) acc = -acc;
    return clip64(acc, clip);
  endfunction

  function void note_elem(input m4i_pkg::elem_item_t it);
    logic signed [63:0] adj[16];
    bit cclip[16];
    bit detclip;
    bit c;
    bit neg;
    logic signed [127:0] det;
    logic signed [127:0] x;
    logic [127:0] dmag;
    logic [127:0] q;
    logic [127:0] lim;
    m4i_pkg::res_item_t r;
    mat[it.element_index] = it.element_value;
    if (!it.last_element) return;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        c = 1'b0;
        adj[j * 4 + i] = cofactor(i, j, c);
        cclip[j * 4 + i] = c;
      end
    end
    det = '0;
    detclip = 1'b0;
    for (int k = 0; k < 4; k++) begin
      x = mat[k];
      det += x * 128'(adj[k * 4]);
      detclip |= cclip[k * 4];
    end
    dmag = det[127] ? -det : det;
    for (int k = 0; k < 16; k++) begin
      r.result_index = 4'(k);
      r.last_result = (k == 15);
      if (det == 0) begin
        r.result_value = '0;
        r.singular = 1'b1;
        r.saturated = 1'b0;
      end else begin
        x = adj[k];
        neg = (adj[k] < 0) != det[127];
        if (x < 0) x = -x;
        q = (128'(x) << (2 * m4i_pkg::FRAC_BITS)) / dmag;
        lim = (128'd1 << (m4i_pkg::ELEM_WIDTH - 1)) - (neg ? 0 : 1);
        c = q > lim;
        if (c) q = lim;
        if (neg) q = -q;
        r.result_value = q[m4i_pkg::ELEM_WIDTH-1:0];
        r.singular = 1'b0;
        r.saturated = c || cclip[k] || detclip;
      end
      pending.push_back(r);
    end
  endfunction

  function void check(input m4i_pkg::res_item_t got);
    m4i_pkg::res_item_t exp;
    checked++;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result item %p", got);
      return;
    end
    exp = pending.pop_front();
    if (got !== exp) begin
      mismatches++;
      if (mismatches <= 10) $display("result mismatch: expected %p actual %p", exp, got);
    end
  endfunction
endclass

module matrix4x4_inverse_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1500000;

  logic clk;
  logic rst;
  logic elem_valid;
  logic elem_ready;
  m4i_pkg::elem_item_t elem;
  logic res_valid;
  logic res_ready;
  m4i_pkg::res_item_t res;

  inverse_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_request;
  int hold_left;
  int cycles;

  matrix4x4_inverse_unit uut (
    .clk(clk), .rst(rst), .elem_valid(elem_valid), .elem_ready(elem_ready), .elem(elem),
    .res_valid(res_valid), .res_ready(res_ready), .res(res)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off when asked
  always @(negedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else if (hold_left > 0) begin
      res_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_request > 0) begin
      res_ready <= 1'b0;
      hold_left <= hold_request;
      hold_request <= 0;
    end else begin
      res_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) sb.check(res);
  end

  // valid stays high into the next item unless the sender idles
  task automatic send_elem(input int idx, input logic [31:0] val, input bit last);
    m4i_pkg::elem_item_t it;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      elem_valid <= 1'b0;
      @(negedge clk);
    end
    it.element_index = 4'(idx);
    it.element_value = val;
    it.last_element = last;
    elem <= it;
    elem_valid <= 1'b1;
    do @(posedge clk); while (!elem_ready);
    sb.note_elem(it);
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 6))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 8)) - 4) << 16;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      4: return 32'($signed($urandom_range(0, 255)) - 128);
      5: return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
      default: return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
    endcase
  endfunction

  // one rewrite of some elements, the final one starting an inversion
  task automatic random_matrix(input int writes);
    for (int i = 0; i < writes; i++)
      send_elem($urandom_range(0, 15), pick_value(), i == writes - 1);
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    elem_valid = 1'b0;
    elem = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = 0;
    hold_left = 0;
    cycles = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // identity
    for (int i = 0; i < 16; i++)
      send_elem(i, (i % 5 == 0) ? 32'h0001_0000 : 32'h0, i == 15);
    // zero row makes it singular
    send_elem(5, 32'h0, 1'b1);
    // tiny diagonal overflows the inverse
    send_elem(5, 32'h0000_0001, 1'b0);
    send_elem(0, 32'hffff_ffff, 1'b0);
    send_elem(10, 32'h0000_0002, 1'b1);
    // extreme elements drive the cofactors into clipping
    send_elem(0, 32'h8000_0000, 1'b0);
    send_elem(5, 32'h7fff_ffff, 1'b0);
    send_elem(1, 32'h7fff_ffff, 1'b0);
    send_elem(4, 32'h8000_0000, 1'b0);
    send_elem(15, 32'h7fff_ffff, 1'b1);

    for (int g = 0; g < 16; g++) begin
      case (g % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      if (g == 5) hold_request = 4000;
      if (g % 5 == 4) begin
        // full well-formed matrix with small entries
        for (int i = 0; i < 16; i++)
          send_elem(i, 32'($signed($urandom_range(0, 8)) - 4) << 16, i == 15);
      end else begin
        random_matrix($urandom_range(1, 8));
      end
    end
    elem_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

`default_nettype wire

// File: filelist.f
hdl/m4i_pkg.sv
hdl/m4i_mul.sv
hdl/m4i_div.sv
hdl/matrix4x4_inverse_unit.sv
bench/matrix4x4_inverse_unit_tb.sv
